// ----- rtl/core/vefc_pkg.sv -----
// shared types, format codes and per-format constants for the vertex element converter
package vefc_pkg;

	typedef enum logic [3:0] {
		FMT_F32  = 4'd0,
		FMT_F16  = 4'd1,
		FMT_I32  = 4'd2,
		FMT_I16  = 4'd3,
		FMT_I8   = 4'd4,
		FMT_I16N = 4'd5,
		FMT_I8N  = 4'd6,
		FMT_U32  = 4'd7,
		FMT_U16  = 4'd8,
		FMT_U8   = 4'd9,
		FMT_U16N = 4'd10,
		FMT_U8N  = 4'd11
	} fmt_t;

	localparam logic [3:0] FMT_LAST = 4'd11;

	typedef enum logic [1:0] {
		K_BYP  = 2'd0,
		K_DEC  = 2'd1,
		K_EINT = 2'd2,
		K_ENRM = 2'd3
	} kind_t;

	localparam logic [7:0] BIAS_INT  = 8'd158;
	localparam logic [7:0] BIAS_FRAC = 8'd126;
	localparam logic [7:0] BIAS_ONE  = 8'd127;

	typedef struct packed {
		logic        act;
		logic        ok;
		kind_t       kind;
		fmt_t        fmt;
		logic        sgn;
		logic        nan;
		logic        xst;
		logic        gd;
		logic [6:0]  lz;
		logic [7:0]  ex;
		logic [63:0] w;
		logic [31:0] byp;
	} pipe_t;

	function automatic logic [15:0] norm_scale(fmt_t f);
		case (f)
			FMT_I16N: norm_scale = 16'd32767;
			FMT_I8N:  norm_scale = 16'd127;
			FMT_U16N: norm_scale = 16'd65535;
			default:  norm_scale = 16'd255;
		endcase
	endfunction

	function automatic logic [4:0] norm_bits(fmt_t f);
		case (f)
			FMT_I16N: norm_bits = 5'd15;
			FMT_I8N:  norm_bits = 5'd7;
			FMT_U16N: norm_bits = 5'd16;
			default:  norm_bits = 5'd8;
		endcase
	endfunction

	function automatic logic [31:0] elem_mask(fmt_t f);
		case (f)
			FMT_I16, FMT_U16, FMT_I16N, FMT_U16N: elem_mask = 32'h0000_FFFF;
			FMT_I8, FMT_U8, FMT_I8N, FMT_U8N:     elem_mask = 32'h0000_00FF;
			default:                              elem_mask = 32'hFFFF_FFFF;
		endcase
	endfunction

endpackage

// ----- rtl/core/vertex_element_format_convert.sv -----
// top level of the vertex element format converter, four-stage pipeline
//
// channel  direction  payload
// in       to block   action, format, raw_bits, float_bits
// out      from block float_out, raw_out, format_ok
//
// one transfer per cycle sustained while out_stall is low
// four register stages: unpack and product, zero count and rounding, shift, pack
// reset clears the stage valid bits only
// a stalled stage holds; earlier stages keep filling until the pipeline is full
module vertex_element_format_convert (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        action,
	input  logic [3:0]  format,
	input  logic [31:0] raw_bits,
	input  logic [31:0] float_bits,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] float_out,
	output logic [31:0] raw_out,
	output logic        format_ok
);
	import vefc_pkg::*;

	pipe_t       c1, c2, c3;
	pipe_t       pipe_s1, pipe_s2, pipe_s3;
	logic [31:0] value;
	logic [31:0] val_s4;
	logic        act_s4, ok_s4;
	logic        v_s1, v_s2, v_s3, v_s4;
	logic        rdy1, rdy2, rdy3, rdy4;

	vefc_front u_front (
		.action     (action),
		.format     (format),
		.raw_bits   (raw_bits),
		.float_bits (float_bits),
		.s1         (c1)
	);

	vefc_mid u_mid (
		.s1 (pipe_s1),
		.s2 (c2)
	);

	vefc_shift u_shift (
		.s2 (pipe_s2),
		.s3 (c3)
	);

	vefc_pack u_pack (
		.s3    (pipe_s3),
		.value (value)
	);

	assign rdy4 = !v_s4 || !out_stall;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign in_stall = !rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) pipe_s1 <= c1;
		if (rdy2) pipe_s2 <= c2;
		if (rdy3) pipe_s3 <= c3;
		if (rdy4) begin
			val_s4 <= value;
			act_s4 <= pipe_s3.act;
			ok_s4 <= pipe_s3.ok;
		end
	end

	assign out_valid = v_s4;
	assign format_ok = ok_s4;
	assign float_out = act_s4 ? 32'd0 : val_s4;
	assign raw_out = act_s4 ? val_s4 : 32'd0;

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (v_s1 && v_s2 && v_s3 && v_s4))
		else $error("input stalled with a free pipeline stage");

	a_stage_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && !(v_s4 && out_stall)) |=> out_valid)
		else $error("stage three transfer lost");

	a_bad_format: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !format_ok) |-> (float_out == 32'd0 && raw_out == 32'd0))
		else $error("invalid format produced nonzero data");

	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (float_out != 32'd0)) |-> (raw_out == 32'd0))
		else $error("both result fields nonzero");

endmodule

// ----- rtl/core/vefc_front.sv -----
// stage 1 logic: unpack, half conversions, magnitudes and normalized product
module vefc_front (
	input  logic             action,
	input  logic [3:0]       format,
	input  logic [31:0]      raw_bits,
	input  logic [31:0]      float_bits,
	output vefc_pkg::pipe_t  s1
);
	import vefc_pkg::*;

	logic        fs;
	logic [7:0]  fe;
	logic [22:0] fm;
	logic [31:0] mag32;
	logic [15:0] x16, mag16;
	logic [7:0]  x8, mag8;
	logic [63:0] r15, r7, r16, r8;
	logic [31:0] hdec;
	logic [15:0] henc;
	logic [4:0]  he;
	logic [23:0] cm;
	logic [7:0]  ce;
	logic        cs, cz;
	logic [39:0] prod;
	fmt_t        f;

	always_comb begin
		fs = float_bits[31];
		fe = float_bits[30:23];
		fm = float_bits[22:0];
		f = fmt_t'(format);
		x16 = raw_bits[15:0];
		x8 = raw_bits[7:0];
		mag32 = raw_bits[31] ? (~raw_bits + 32'd1) : raw_bits;
		mag16 = x16[15] ? (~x16 + 16'd1) : x16;
		mag8 = x8[7] ? (~x8 + 8'd1) : x8;
		for (int i = 0; i < 64; i++) begin
			r15[63-i] = mag16[14-(i%15)];
			r7[63-i] = mag8[6-(i%7)];
			r16[63-i] = x16[15-(i%16)];
			r8[63-i] = x8[7-(i%8)];
		end
		// half decode, subnormals flush
		he = x16[14:10];
		if (he == 5'd0)
			hdec = {x16[15], 31'b0};
		else if (he == 5'd31)
			hdec = {x16[15], 8'hFF, x16[9:0], 13'b0};
		else
			hdec = {x16[15], 3'b0, he + 5'd0, x16[9:0], 13'b0} + {1'b0, 8'd112, 23'b0};
		// half encode
		if (fe == 8'hFF)
			henc = {fs, 5'h1F, (fm != 23'd0), 9'b0};
		else if (fe >= 8'd143)
			henc = {fs, 5'h1F, 10'b0};
		else if (fe <= 8'd112)
			henc = {fs, 15'b0};
		else
			henc = {fs, 5'(fe - 8'd112), fm[22:13]} + {15'b0, fm[12]};
		// clamped normalized operand
		cm = 24'h80_0000;
		ce = BIAS_ONE;
		cs = 1'b0;
		cz = 1'b0;
		if ((fe == 8'hFF) && (fm != 23'd0)) begin
			cs = 1'b0;
		end else if (((f == FMT_U16N) || (f == FMT_U8N)) && fs) begin
			cz = 1'b1;
		end else if ((fe > 8'd127) || ((fe == 8'd127) && (fm != 23'd0))) begin
			cs = fs;
		end else if (fe == 8'd0) begin
			cz = 1'b1;
		end else begin
			cm = {1'b1, fm};
			ce = fe;
			cs = fs;
		end
		prod = cm * norm_scale(f);

		s1 = '0;
		s1.act = action;
		s1.fmt = f;
		s1.kind = K_BYP;
		s1.ok = (format <= FMT_LAST);
		if (format <= FMT_LAST) begin
			if (!action) begin
				s1.ex = BIAS_INT;
				case (f)
					FMT_F32: s1.byp = raw_bits;
					FMT_F16: s1.byp = hdec;
					FMT_I32: begin
						s1.kind = K_DEC;
						s1.sgn = raw_bits[31];
						s1.w = {mag32, 32'b0};
					end
					FMT_I16: begin
						s1.kind = K_DEC;
						s1.sgn = x16[15];
						s1.w = {16'b0, mag16, 32'b0};
					end
					FMT_I8: begin
						s1.kind = K_DEC;
						s1.sgn = x8[7];
						s1.w = {24'b0, mag8, 32'b0};
					end
					FMT_U32: begin
						s1.kind = K_DEC;
						s1.w = {raw_bits, 32'b0};
					end
					FMT_U16: begin
						s1.kind = K_DEC;
						s1.w = {16'b0, x16, 32'b0};
					end
					FMT_U8: begin
						s1.kind = K_DEC;
						s1.w = {24'b0, x8, 32'b0};
					end
					FMT_I16N: begin
						s1.kind = K_DEC;
						s1.sgn = x16[15];
						if ((x16 == 16'h8000) || (x16 == 16'h8001) || (x16 == 16'h7FFF)) begin
							s1.w = {1'b1, 63'b0};
							s1.ex = BIAS_ONE;
						end else begin
							s1.w = r15;
							s1.ex = BIAS_FRAC;
							s1.xst = (mag16 != 16'd0);
						end
					end
					FMT_I8N: begin
						s1.kind = K_DEC;
						s1.sgn = x8[7];
						if ((x8 == 8'h80) || (x8 == 8'h81) || (x8 == 8'h7F)) begin
							s1.w = {1'b1, 63'b0};
							s1.ex = BIAS_ONE;
						end else begin
							s1.w = r7;
							s1.ex = BIAS_FRAC;
							s1.xst = (mag8 != 8'd0);
						end
					end
					FMT_U16N: begin
						s1.kind = K_DEC;
						if (x16 == 16'hFFFF) begin
							s1.w = {1'b1, 63'b0};
							s1.ex = BIAS_ONE;
						end else begin
							s1.w = r16;
							s1.ex = BIAS_FRAC;
							s1.xst = (x16 != 16'd0);
						end
					end
					FMT_U8N: begin
						s1.kind = K_DEC;
						if (x8 == 8'hFF) begin
							s1.w = {1'b1, 63'b0};
							s1.ex = BIAS_ONE;
						end else begin
							s1.w = r8;
							s1.ex = BIAS_FRAC;
							s1.xst = (x8 != 8'd0);
						end
					end
					default: s1.byp = 32'd0;
				endcase
			end else begin
				case (f)
					FMT_F32: s1.byp = float_bits;
					FMT_F16: s1.byp = {16'b0, henc};
					FMT_I32, FMT_I16, FMT_I8, FMT_U32, FMT_U16, FMT_U8: begin
						s1.kind = K_EINT;
						s1.sgn = fs;
						s1.nan = (fe == 8'hFF) && (fm != 23'd0);
						s1.ex = fe;
						s1.w = {40'b0, (fe != 8'd0), fm};
					end
					FMT_I16N, FMT_I8N, FMT_U16N, FMT_U8N: begin
						s1.kind = K_ENRM;
						s1.sgn = cs;
						s1.ex = ce;
						s1.w = cz ? 64'd0 : {24'b0, prod};
					end
					default: s1.byp = 32'd0;
				endcase
			end
		end
	end

endmodule

// ----- rtl/core/vefc_mid.sv -----
// stage 2 logic: leading zero count, integer truncation, product rounding to single
module vefc_mid (
	input  vefc_pkg::pipe_t s1,
	output vefc_pkg::pipe_t s2
);
	import vefc_pkg::*;

	logic [6:0]  cnt;
	logic        found;
	logic [32:0] tr;
	logic [56:0] sh57;
	logic [5:0]  n6, kk;
	logic [40:0] p, t, q, gv, pp;
	logic        hb, g, st;

	always_comb begin
		cnt = 7'd0;
		found = 1'b0;
		for (int i = 63; i >= 0; i--) begin
			if (!found) begin
				if (s1.w[i])
					found = 1'b1;
				else
					cnt = cnt + 7'd1;
			end
		end

		sh57 = {33'b0, s1.w[23:0]} << (s1.ex - 8'd127);
		if (s1.ex < 8'd127)
			tr = 33'd0;
		else if (s1.ex >= 8'd160)
			tr = '1;
		else
			tr = sh57[55:23];

		n6 = {1'b0, norm_bits(s1.fmt)};
		p = {1'b0, s1.w[39:0]};
		t = p >> (n6 + 6'd23);
		hb = t[0];
		kk = hb ? n6 : (n6 - 6'd1);
		q = p >> kk;
		gv = p >> (kk - 6'd1);
		g = gv[0];
		st = ((p & ((41'd1 << (kk - 6'd1)) - 41'd1)) != 41'd0);
		q = q + {40'b0, g & (st | q[0])};
		pp = q << kk;

		s2 = s1;
		case (s1.kind)
			K_DEC:   s2.lz = cnt;
			K_EINT:  s2.w = {31'b0, tr};
			K_ENRM:  s2.w = {23'b0, pp};
			default: s2.lz = 7'd0;
		endcase
	end

endmodule

// ----- rtl/core/vefc_shift.sv -----
// stage 3 logic: normalize shift, integer clamp, scale to integer with half bit
module vefc_shift (
	input  vefc_pkg::pipe_t s2,
	output vefc_pkg::pipe_t s3
);
	import vefc_pkg::*;

	logic [63:0]        nw;
	logic signed [34:0] sv, hi, lo, cv;
	logic [7:0]         sh8;
	logic [40:0]        ip, hv;

	always_comb begin
		nw = s2.w << s2.lz;

		sv = s2.sgn ? -$signed({2'b0, s2.w[32:0]}) : $signed({2'b0, s2.w[32:0]});
		case (s2.fmt)
			FMT_I32: begin hi = 35'sd2147483647; lo = -35'sd2147483648; end
			FMT_I16: begin hi = 35'sd32767; lo = -35'sd32768; end
			FMT_I8:  begin hi = 35'sd127; lo = -35'sd128; end
			FMT_U32: begin hi = 35'sd4294967295; lo = 35'sd0; end
			FMT_U16: begin hi = 35'sd65535; lo = 35'sd0; end
			default: begin hi = 35'sd255; lo = 35'sd0; end
		endcase
		if (s2.nan || (sv > hi))
			cv = hi;
		else if (sv < lo)
			cv = lo;
		else
			cv = sv;

		sh8 = 8'd150 - s2.ex;
		ip = s2.w[40:0] >> sh8;
		hv = s2.w[40:0] >> (sh8 - 8'd1);

		s3 = s2;
		case (s2.kind)
			K_DEC: begin
				s3.w = {40'b0, nw[63:40]};
				s3.gd = nw[39];
				s3.xst = s2.xst | (|nw[38:0]);
				s3.ex = s2.ex - {1'b0, s2.lz};
			end
			K_EINT: s3.w = {32'b0, cv[31:0]};
			K_ENRM: begin
				s3.w = {23'b0, ip};
				s3.gd = hv[0];
			end
			default: s3.gd = 1'b0;
		endcase
	end

endmodule

// ----- rtl/core/vefc_pack.sv -----
// stage 4 logic: final rounding, packing and element masking
module vefc_pack (
	input  vefc_pkg::pipe_t s3,
	output logic [31:0]     value
);
	import vefc_pkg::*;

	logic [24:0] m25;
	logic [7:0]  e;
	logic [17:0] t;
	logic [31:0] r;

	always_comb begin
		m25 = {1'b0, s3.w[23:0]} + {24'b0, s3.gd & (s3.xst | s3.w[0])};
		e = s3.ex + {7'b0, m25[24]};
		t = s3.w[17:0] + {17'b0, s3.gd};
		r = s3.sgn ? -{14'b0, t} : {14'b0, t};
		case (s3.kind)
			K_DEC: begin
				if (!s3.w[23])
					value = 32'd0;
				else
					value = {s3.sgn, e, m25[24] ? 23'd0 : m25[22:0]};
			end
			K_EINT:  value = s3.w[31:0] & elem_mask(s3.fmt);
			K_ENRM:  value = r & elem_mask(s3.fmt);
			default: value = s3.byp;
		endcase
	end

endmodule

// ----- tb/tb_vertex_element_format_convert.sv -----
// self-checking testbench for the vertex element format converter
module tb_vertex_element_format_convert;
	timeunit 1ns;
	timeprecision 1ps;
	import vefc_pkg::*;

	typedef struct {
		logic        action;
		logic [3:0]  format;
		logic [31:0] raw_bits;
		logic [31:0] float_bits;
	} elem_req_t;

	typedef struct {
		logic [31:0] float_out;
		logic [31:0] raw_out;
		logic        format_ok;
	} elem_res_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid;
	logic        in_stall;
	logic        action;
	logic [3:0]  format;
	logic [31:0] raw_bits;
	logic [31:0] float_bits;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] float_out;
	logic [31:0] raw_out;
	logic        format_ok;

	elem_req_t pending_reqs[$];
	elem_res_t expected_results[$];
	int        errors = 0;
	int        sent = 0;
	int        rcvd = 0;
	int        n_dec = 0;
	int        n_enc = 0;
	int        n_bad = 0;
	int        in_gap = 0;
	int        out_gap = 0;
	int        hold_left = 0;
	bit        hold_done = 1'b0;
	longint    cycles = 0;

	vertex_element_format_convert i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.action(action), .format(format), .raw_bits(raw_bits), .float_bits(float_bits),
		.out_valid(out_valid), .out_stall(out_stall),
		.float_out(float_out), .raw_out(raw_out), .format_ok(format_ok)
	);

	always #10 clk = ~clk;

	// correctly rounded single of num/den, nearest even
	function automatic logic [31:0] ratio_to_single(logic neg, logic [31:0] num, logic [16:0] den);
		logic [95:0] q;
		logic [95:0] r;
		logic [95:0] rem;
		logic [95:0] half;
		logic [24:0] mant;
		int          p;
		int          sh;
		int          ex;
		if (num == 0)
			return 32'h0;
		q = {num, 64'h0} / den;
		r = {num, 64'h0} % den;
		p = 0;
		for (int i = 95; i >= 0; i--)
			if (q[i] && p == 0) p = i;
		sh = p - 23;
		mant = 25'(q >> sh);
		rem = q & ((96'h1 << sh) - 1);
		half = 96'h1 << (sh - 1);
		ex = p - 64;
		if (rem > half || (rem == half && (r != 0 || mant[0])))
			mant = mant + 1;
		if (mant[24]) begin
			mant = mant >> 1;
			ex = ex + 1;
		end
		return {neg, 8'(ex + 127), mant[22:0]};
	endfunction

	function automatic logic [31:0] half_to_single(logic [15:0] h);
		logic [31:0] sgn;
		sgn = {h[15], 31'h0};
		if (h[14:10] == 5'd0)
			return sgn;
		if (h[14:10] == 5'd31)
			return sgn | 32'h7F80_0000 | {9'h0, h[9:0], 13'h0};
		return sgn | {1'b0, 8'(h[14:10] + 8'd112), h[9:0], 13'h0};
	endfunction

	function automatic logic [15:0] single_to_half(logic [31:0] b);
		logic [15:0] sgn;
		logic [15:0] r;
		int          e;
		sgn = {b[31], 15'h0};
		e = int'(b[30:23]) - 112;
		if (b[30:23] == 8'hFF)
			return sgn | 16'h7C00 | (b[22:0] != 0 ? 16'h0200 : 16'h0);
		if (e >= 31)
			return sgn | 16'h7C00;
		if (e <= 0)
			return sgn;
		r = sgn | 16'(e << 10) | {6'h0, b[22:13]};
		if (b[12])
			r = r + 1;
		return r;
	endfunction

	// truncating integer encode with clamp, nan to the upper limit
	function automatic logic [31:0] single_to_int(logic [31:0] b, longint lo, longint hi);
		logic [63:0] m;
		logic [63:0] mag;
		longint      v;
		int          sh;
		if (b[30:23] == 8'hFF && b[22:0] != 0)
			return 32'(hi);
		m = {40'h0, 1'b1, b[22:0]};
		sh = int'(b[30:23]) - 150;
		if (b[30:23] < 8'd127)
			mag = 0;
		else if (sh > 30)
			mag = 64'h1_0000_0000_0;
		else if (sh >= 0)
			mag = m << sh;
		else
			mag = m >> (-sh);
		if (b[31])
			v = (mag > 64'(-lo)) ? lo : -longint'(mag);
		else
			v = (mag > 64'(hi)) ? hi : longint'(mag);
		return 32'(v);
	endfunction

	// clamp, single-precision multiply by scale, round half away from zero
	function automatic logic [31:0] single_to_norm(logic [31:0] b, logic sgnd, int scale);
		logic [63:0] m;
		logic [63:0] prod;
		logic [63:0] rem;
		logic [63:0] half;
		logic [63:0] mant;
		logic [63:0] t;
		int          k;
		int          p;
		int          sh;
		logic        neg;
		neg = b[31];
		if (b[30:23] == 8'hFF && b[22:0] != 0) begin
			neg = 1'b0;
			m = 64'h80_0000;
			k = -23;
		end else if (b[30:23] >= 8'd127) begin
			m = 64'h80_0000;
			k = -23;
		end else if (b[30:23] == 8'd0) begin
			m = {41'h0, b[22:0]};
			k = -149;
		end else begin
			m = {40'h0, 1'b1, b[22:0]};
			k = int'(b[30:23]) - 150;
		end
		if (m == 0 || (neg && !sgnd))
			return 32'h0;
		prod = m * 64'(scale);
		p = 0;
		for (int i = 63; i >= 0; i--)
			if (prod[i] && p == 0) p = i;
		mant = prod;
		if (p > 23) begin
			sh = p - 23;
			mant = prod >> sh;
			rem = prod & ((64'h1 << sh) - 1);
			half = 64'h1 << (sh - 1);
			if (rem > half || (rem == half && mant[0]))
				mant = mant + 1;
			k = k + sh;
		end
		if (k >= 0)
			t = mant << k;
		else if (-k > 25)
			t = 0;
		else
			t = (mant >> (-k)) + 64'(mant[-k - 1]);
		return neg ? 32'(-t) : 32'(t);
	endfunction

	function automatic elem_res_t convert_element(elem_req_t q);
		elem_res_t   res;
		longint      x;
		logic [31:0] mag;
		res.float_out = 32'h0;
		res.raw_out = 32'h0;
		res.format_ok = (q.format <= FMT_LAST);
		if (!res.format_ok)
			return res;
		if (!q.action) begin
			case (fmt_t'(q.format))
				FMT_I32, FMT_I16, FMT_I8, FMT_I16N, FMT_I8N: begin
					case (fmt_t'(q.format))
						FMT_I32:          x = longint'($signed(q.raw_bits));
						FMT_I16, FMT_I16N: x = longint'($signed(q.raw_bits[15:0]));
						default:          x = longint'($signed(q.raw_bits[7:0]));
					endcase
					mag = 32'(x < 0 ? -x : x);
				end
				default: mag = 32'h0;
			endcase
			case (fmt_t'(q.format))
				FMT_F32:  res.float_out = q.raw_bits;
				FMT_F16:  res.float_out = half_to_single(q.raw_bits[15:0]);
				FMT_I32, FMT_I16, FMT_I8: res.float_out = ratio_to_single(x < 0, mag, 17'd1);
				FMT_I16N: res.float_out = (mag > 32767) ? 32'hBF80_0000 :
					ratio_to_single(x < 0, mag, 17'd32767);
				FMT_I8N:  res.float_out = (mag > 127) ? 32'hBF80_0000 :
					ratio_to_single(x < 0, mag, 17'd127);
				FMT_U32:  res.float_out = ratio_to_single(1'b0, q.raw_bits, 17'd1);
				FMT_U16:  res.float_out = ratio_to_single(1'b0, {16'h0, q.raw_bits[15:0]}, 17'd1);
				FMT_U8:   res.float_out = ratio_to_single(1'b0, {24'h0, q.raw_bits[7:0]}, 17'd1);
				FMT_U16N: res.float_out = ratio_to_single(1'b0, {16'h0, q.raw_bits[15:0]}, 17'd65535);
				default:  res.float_out = ratio_to_single(1'b0, {24'h0, q.raw_bits[7:0]}, 17'd255);
			endcase
		end else begin
			case (fmt_t'(q.format))
				FMT_F32:  res.raw_out = q.float_bits;
				FMT_F16:  res.raw_out = {16'h0, single_to_half(q.float_bits)};
				FMT_I32:  res.raw_out = single_to_int(q.float_bits, -64'sd2147483648, 64'sd2147483647);
				FMT_I16:  res.raw_out = single_to_int(q.float_bits, -32768, 32767) & 32'hFFFF;
				FMT_I8:   res.raw_out = single_to_int(q.float_bits, -128, 127) & 32'hFF;
				FMT_I16N: res.raw_out = single_to_norm(q.float_bits, 1'b1, 32767) & 32'hFFFF;
				FMT_I8N:  res.raw_out = single_to_norm(q.float_bits, 1'b1, 127) & 32'hFF;
				FMT_U32:  res.raw_out = single_to_int(q.float_bits, 0, 64'sd4294967295);
				FMT_U16:  res.raw_out = single_to_int(q.float_bits, 0, 65535) & 32'hFFFF;
				FMT_U8:   res.raw_out = single_to_int(q.float_bits, 0, 255) & 32'hFF;
				FMT_U16N: res.raw_out = single_to_norm(q.float_bits, 1'b0, 65535) & 32'hFFFF;
				default:  res.raw_out = single_to_norm(q.float_bits, 1'b0, 255) & 32'hFF;
			endcase
		end
		return res;
	endfunction

	function automatic logic [31:0] pick_single();
		logic [31:0] b;
		b = $urandom;
		case ($urandom_range(0, 9))
			0: b[30:23] = 8'hFF;
			1: b[30:23] = 8'h00;
			2: b[30:0] = 31'(32'h3F80_0000 + $urandom_range(0, 3) - 1);
			3: b[22:0] = 23'h0;
			4, 5: b[30:23] = 8'($urandom_range(100, 165));
			6, 7: b[30:23] = 8'($urandom_range(118, 127));
			default: ;
		endcase
		return b;
	endfunction

	function automatic logic [31:0] pick_raw();
		logic [31:0] r;
		r = $urandom;
		case ($urandom_range(0, 5))
			0: r[15:0] = {$urandom_range(0, 1) ? 16'h8000 : 16'h7FFF} ^ 16'($urandom_range(0, 1));
			1: r[7:0] = {$urandom_range(0, 1) ? 8'h80 : 8'h7F} ^ 8'($urandom_range(0, 1));
			2: r[14:10] = $urandom_range(0, 1) ? 5'd0 : 5'd31;
			default: ;
		endcase
		return r;
	endfunction

	task automatic add_req(logic act, logic [3:0] fmt, logic [31:0] rb, logic [31:0] fb);
		elem_req_t q;
		q.action = act;
		q.format = fmt;
		q.raw_bits = rb;
		q.float_bits = fb;
		pending_reqs.push_back(q);
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			action <= 1'b0;
			format <= 4'd0;
			raw_bits <= 32'h0;
			float_bits <= 32'h0;
		end else begin
			elem_req_t q;
			if (in_valid && !in_stall) begin
				q.action = action;
				q.format = format;
				q.raw_bits = raw_bits;
				q.float_bits = float_bits;
				expected_results.push_back(convert_element(q));
				sent++;
				if (format > FMT_LAST) n_bad++;
				else if (action) n_enc++;
				else n_dec++;
			end
			if (!in_valid || !in_stall) begin
				if (in_gap == 0 && pending_reqs.size() > 150 && $urandom_range(0, 11) == 0)
					in_gap = $urandom_range(1, 12);
				if (in_gap > 0 || pending_reqs.size() == 0) begin
					if (in_gap > 0) in_gap--;
					in_valid <= 1'b0;
				end else begin
					q = pending_reqs.pop_front();
					in_valid <= 1'b1;
					action <= q.action;
					format <= q.format;
					raw_bits <= q.raw_bits;
					float_bits <= q.float_bits;
				end
			end
		end
	end

	// receiver and checker
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			elem_res_t e;
			if (out_valid && !out_stall) begin
				rcvd++;
				if (expected_results.size() == 0) begin
					errors++;
					$display("%t: transfer with no expected result: float %h raw %h ok %b",
						$time, float_out, raw_out, format_ok);
				end else begin
					e = expected_results.pop_front();
					if (float_out !== e.float_out) begin
						errors++;
						$display("%t: float_out expected %h actual %h", $time, e.float_out, float_out);
					end
					if (raw_out !== e.raw_out) begin
						errors++;
						$display("%t: raw_out expected %h actual %h", $time, e.raw_out, raw_out);
					end
					if (format_ok !== e.format_ok) begin
						errors++;
						$display("%t: format_ok expected %b actual %b", $time, e.format_ok, format_ok);
					end
				end
			end
			if (!hold_done && rcvd >= 300) begin
				hold_done = 1'b1;
				hold_left = 300;
			end
			if (out_gap == 0 && hold_left == 0 && pending_reqs.size() > 150 &&
				$urandom_range(0, 9) == 0)
				out_gap = $urandom_range(1, 12);
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (out_gap > 0) begin
				out_gap--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 200000) begin
			$display("timeout after %0d cycles, %0d results still expected",
				cycles, expected_results.size());
			$display("vertex_element_format_convert regression: fail");
			$finish;
		end
	end

	initial begin
		// directed: every format both ways, edge values, invalid codes
		for (int f = 0; f < 16; f++) begin
			add_req(1'b0, 4'(f), 32'hFFFF_8080, 32'h0);
			add_req(1'b1, 4'(f), 32'h0, 32'h7FC0_0001);
		end
		add_req(1'b0, FMT_F16, 32'h0000_8001, 32'h0);
		add_req(1'b0, FMT_F16, 32'h0000_7C01, 32'h0);
		add_req(1'b0, FMT_I32, 32'h8000_0000, 32'h0);
		add_req(1'b0, FMT_U32, 32'hFFFF_FFFF, 32'h0);
		add_req(1'b0, FMT_U16N, 32'h0000_FFFF, 32'h0);
		add_req(1'b1, FMT_F16, 32'h0, 32'h477F_F000);
		add_req(1'b1, FMT_F16, 32'h0, 32'hB300_0000);
		add_req(1'b1, FMT_I32, 32'h0, 32'hFF80_0000);
		add_req(1'b1, FMT_U32, 32'h0, 32'h7F80_0000);
		add_req(1'b1, FMT_I16N, 32'h0, 32'hBF00_0000);
		add_req(1'b1, FMT_U8N, 32'h0, 32'h3F00_0000);
		add_req(1'b1, FMT_I8, 32'h0, 32'h8000_0000);
		add_req(1'b1, FMT_I8N, 32'h0, 32'hC000_0000);
		add_req(1'b1, FMT_U16, 32'h0, 32'hBF7F_FFFF);
		for (int i = 0; i < 1700; i++)
			add_req(1'($urandom), $urandom_range(0, 19) == 0 ? 4'($urandom_range(12, 15)) :
				4'($urandom_range(0, 11)), pick_raw(), pick_single());
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		$display("covered %0d decodes, %0d encodes and %0d invalid codes over %0d transfers",
			n_dec, n_enc, n_bad, sent);
		$display("with random stalls on both sides and one long receiver hold-off");
		if (errors == 0 && expected_results.size() == 0)
			$display("vertex_element_format_convert regression: pass");
		else
			$display("vertex_element_format_convert regression: fail");
		$finish;
	end

endmodule
